FILE: hw/rtl/tlfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfe_pkg: shared types and constants of the type-length frame extractor
// Holds the header position codes, the result record and the reset value of
// the maximum payload length register.
// ----------------------------------------------------------------------------
package tlfe_pkg;

    // Position within the frame: type byte, four length bytes, then payload.
    typedef enum logic [2:0] {
        POS_TYPE    = 3'd0,
        POS_LEN0    = 3'd1,
        POS_LEN1    = 3'd2,
        POS_LEN2    = 3'd3,
        POS_LEN3    = 3'd4,
        POS_PAYLOAD = 3'd5
    } tlfe_pos_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [7:0] msg_type;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       msg_last;
        logic       oversize_error;
    } tlfe_result_t;

    // Maximum payload length after reset (one mebibyte).
    localparam logic [31:0] RESET_MAX_LEN = 32'd1048576;

endpackage

FILE: hw/rtl/tlfe_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfe_parser: frame header parser and payload counter
// Keeps the per-stream parse state and works out, in one pass of logic, the
// result (if any) that the registered input byte causes.
// ----------------------------------------------------------------------------
module tlfe_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_fire,
    input  logic [7:0]            data_byte,
    input  logic                  chunk_end,
    input  logic [31:0]           max_len,
    output logic                  res_valid,
    output tlfe_pkg::tlfe_result_t res
);

    tlfe_pkg::tlfe_pos_t pos_reg;
    tlfe_pkg::tlfe_pos_t pos_next;
    logic [7:0]          type_reg;
    logic [7:0]          type_next;
    logic [31:0]         remaining_reg;
    logic [31:0]         remaining_next;
    logic                discard_reg;
    logic                discard_next;
    logic [31:0]         full_len;

    // The complete length once the last length byte arrives.
    assign full_len = {data_byte, remaining_reg[23:0]};

    // Next parse state and the result of the current byte.
    always_comb
    begin
        pos_next       = pos_reg;
        type_next      = type_reg;
        remaining_next = remaining_reg;
        discard_next   = discard_reg;
        res_valid      = 1'b0;
        res            = '0;
        res.msg_type   = type_reg;

        if (discard_reg)
        begin
            // Bytes are dropped until the end of the chunk.
            if (chunk_end)
            begin
                discard_next   = 1'b0;
                pos_next       = tlfe_pkg::POS_TYPE;
                remaining_next = '0;
            end
        end
        else
        begin
            unique case (pos_reg)
                tlfe_pkg::POS_TYPE:
                begin
                    type_next      = data_byte;
                    remaining_next = '0;
                    pos_next       = tlfe_pkg::POS_LEN0;
                end
                tlfe_pkg::POS_LEN0:
                begin
                    remaining_next[7:0] = data_byte;
                    pos_next            = tlfe_pkg::POS_LEN1;
                end
                tlfe_pkg::POS_LEN1:
                begin
                    remaining_next[15:8] = data_byte;
                    pos_next             = tlfe_pkg::POS_LEN2;
                end
                tlfe_pkg::POS_LEN2:
                begin
                    remaining_next[23:16] = data_byte;
                    pos_next              = tlfe_pkg::POS_LEN3;
                end
                tlfe_pkg::POS_LEN3:
                begin
                    // Header complete: check the length against the limit.
                    remaining_next = full_len;
                    pos_next       = tlfe_pkg::POS_PAYLOAD;
                    if (full_len > max_len)
                    begin
                        res_valid          = 1'b1;
                        res.msg_last       = 1'b1;
                        res.oversize_error = 1'b1;
                        pos_next           = tlfe_pkg::POS_TYPE;
                        remaining_next     = '0;
                        discard_next       = ~chunk_end;
                    end
                    else if (full_len == '0)
                    begin
                        res_valid    = 1'b1;
                        res.msg_last = 1'b1;
                        pos_next     = tlfe_pkg::POS_TYPE;
                    end
                end
                default:
                begin
                    // Payload phase; the unused codes behave the same way.
                    res_valid        = 1'b1;
                    res.payload_byte = data_byte;
                    res.byte_valid   = 1'b1;
                    if (remaining_reg <= 32'd1)
                    begin
                        res.msg_last   = 1'b1;
                        remaining_next = '0;
                        pos_next       = tlfe_pkg::POS_TYPE;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - 32'd1;
                    end
                end
            endcase
        end

        // Without a byte in the input register nothing is produced.
        if (!item_valid)
        begin
            res_valid = 1'b0;
        end
    end

    // Parse state advances only when the byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= tlfe_pkg::POS_TYPE;
            type_reg      <= '0;
            remaining_reg <= '0;
            discard_reg   <= 1'b0;
        end
        else if (item_fire)
        begin
            pos_reg       <= pos_next;
            type_reg      <= type_next;
            remaining_reg <= remaining_next;
            discard_reg   <= discard_next;
        end
    end

    // While dropping bytes the parser sits at the start of a header.
    a_discard_at_type: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> (pos_reg == tlfe_pkg::POS_TYPE))
        else $error("discard set outside the type position");

    // A dropped byte never gives a result.
    a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> !res_valid)
        else $error("result produced while discarding");

    // The payload counter is never zero during the payload phase.
    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == tlfe_pkg::POS_PAYLOAD) |-> (remaining_reg != '0))
        else $error("payload phase with nothing remaining");

endmodule

FILE: hw/rtl/type_length_frame_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// type_length_frame_extractor: streaming type-length-value deframer
// Splits a chunked byte stream into frames of type, 32-bit little-endian
// length and payload, passing payload bytes on one per request.
// ----------------------------------------------------------------------------
// Path: a result moves from the input register through the parse logic into
// the output register, held back only while an earlier result is stalled there.
// Throughput: one byte per cycle; the input register, parse logic and output
// register form a two-stage pipeline that stalls only on output back-pressure.
// Reset: rst_n clears both pipeline stages and the parse state, and sets the
// maximum payload length to 1048576.
module type_length_frame_extractor
(
    input  logic        clk,
    input  logic        rst_n,
    // Input byte stream
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        chunk_end,
    // Result stream
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  msg_type,
    output logic [7:0]  payload_byte,
    output logic        byte_valid,
    output logic        msg_last,
    output logic        oversize_error,
    // Configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] max_payload_len
);

    logic                   in_vld_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_cend_reg;
    logic [31:0]            max_len_reg;
    logic                   out_vld_reg;
    tlfe_pkg::tlfe_result_t out_reg;
    logic                   res_valid;
    tlfe_pkg::tlfe_result_t res;
    logic                   fire;
    logic                   accept;

    // The held byte moves on unless its result would meet a full, stalled output.
    assign fire      = in_vld_reg && (!res_valid || !out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !fire;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= tlfe_pkg::RESET_MAX_LEN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= max_payload_len;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= data_byte;
            in_cend_reg <= chunk_end;
        end
    end

    // Header parser and payload counter.
    tlfe_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(in_vld_reg),
        .item_fire (fire),
        .data_byte (in_byte_reg),
        .chunk_end (in_cend_reg),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire && res_valid)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_vld_reg;
    assign msg_type       = out_reg.msg_type;
    assign payload_byte   = out_reg.payload_byte;
    assign byte_valid     = out_reg.byte_valid;
    assign msg_last       = out_reg.msg_last;
    assign oversize_error = out_reg.oversize_error;

    // A result is never loaded over one that is still stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_stall) |-> !(fire && res_valid))
        else $error("stalled result overwritten");

    // An error request is an empty, final result.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.oversize_error) |->
            (out_reg.msg_last && !out_reg.byte_valid && (out_reg.payload_byte == 8'd0)))
        else $error("malformed error result");

    // An empty result carries a zero payload byte.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_reg.byte_valid) |-> (out_reg.payload_byte == 8'd0))
        else $error("empty result with non-zero payload byte");

endmodule
